// File: src/ctt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_pkg: shared types and constants of the comment-aware text tokenizer
// Scan modes, result kinds, register indexes and the word formats that pass
// between the scanner, the queue and the emitter.
// ----------------------------------------------------------------------------
package ctt_pkg;

  localparam logic [10:0] TOKEN_LIMIT_MIN   = 11'd2;
  localparam logic [10:0] TOKEN_LIMIT_MAX   = 11'd1024;
  localparam logic [10:0] TOKEN_LIMIT_RESET = 11'd1024;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_LBRACE  = 8'h7b;
  localparam logic [7:0] CH_RBRACE  = 8'h7d;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    CFG_TOKEN_LIMIT    = 2'd0,
    CFG_COLON_IS_BREAK = 2'd1,
    CFG_FOLD_CASE      = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_SLASH      = 3'd1,
    MODE_LINE       = 3'd2,
    MODE_BLOCK      = 3'd3,
    MODE_BLOCK_STAR = 3'd4,
    MODE_WORD       = 3'd5,
    MODE_QUOTE      = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_EOT  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [10:0] token_limit;
    logic        colon_is_break;
    logic        fold_case;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  ch;
    logic        quoted;
    logic [9:0]  len;
  } result_t;

  // Up to four results caused by one text byte, oldest at index 0.
  typedef struct packed {
    result_t [3:0] res;
    logic [2:0]    count;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// File: src/ctt_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_scanner: front end of the tokenizer
// Classifies each accepted byte against the scan mode and builds the bundle
// of results that the byte causes.
// ----------------------------------------------------------------------------
module ctt_scanner (
  input  logic             clk,
  input  logic             rst,
  input  ctt_pkg::cfg_t    cfg,
  input  logic             step,
  input  logic [7:0]       text_byte,
  output logic             push,
  output ctt_pkg::bundle_t bundle
);
  import ctt_pkg::*;

  mode_t       mode;
  mode_t       mode_next;
  logic [9:0]  chars;
  logic [9:0]  chars_next;

  logic [10:0] lim;
  logic [10:0] lim_m1;
  logic [9:0]  cap;
  logic        is_brk;
  logic        is_sp;
  logic [7:0]  cf;

  result_t [3:0] res;
  logic [2:0]    cnt;
  logic          run_word;
  logic          run_idle;

  function automatic result_t mk(kind_t k, logic [7:0] ch, logic q, logic [9:0] len);
    result_t r;
    r.kind   = k;
    r.ch     = ch;
    r.quoted = q;
    r.len    = len;
    return r;
  endfunction

  always_comb begin
    lim = cfg.token_limit;
    if (lim < TOKEN_LIMIT_MIN) lim = TOKEN_LIMIT_MIN;
    if (lim > TOKEN_LIMIT_MAX) lim = TOKEN_LIMIT_MAX;
    lim_m1 = lim - 11'd1;
    cap = lim_m1[9:0];
  end

  assign is_brk = (text_byte == CH_LBRACE) || (text_byte == CH_RBRACE) ||
                  (text_byte == CH_LPAREN) || (text_byte == CH_RPAREN) ||
                  (text_byte == CH_SQUOTE) ||
                  (cfg.colon_is_break && (text_byte == CH_COLON));
  assign is_sp  = (text_byte <= CH_SPACE) || text_byte[7];
  assign cf = (cfg.fold_case && (text_byte >= CH_UPPER_A) && (text_byte <= CH_UPPER_Z))
            ? text_byte + CASE_OFFSET : text_byte;

  // Sequential walk of one byte; at most four results are pushed.
  always_comb begin
    mode_next  = mode;
    chars_next = chars;
    res        = '0;
    cnt        = 3'd0;
    run_word   = 1'b0;
    run_idle   = 1'b0;

    case (mode)
      MODE_SLASH: begin
        if (text_byte == CH_SLASH) begin
          mode_next = MODE_LINE;
        end else if (text_byte == CH_STAR) begin
          mode_next = MODE_BLOCK;
        end else begin
          // The held slash starts a word of its own.
          res[cnt[1:0]] = mk(KIND_CHAR, CH_SLASH, 1'b0, 10'd0);
          cnt = cnt + 3'd1;
          chars_next = 10'd1;
          if (chars_next >= cap) begin
            res[cnt[1:0]] = mk(KIND_END, 8'd0, 1'b0, chars_next);
            cnt = cnt + 3'd1;
            chars_next = 10'd0;
            mode_next  = MODE_IDLE;
            run_idle   = 1'b1;
          end else begin
            mode_next = MODE_WORD;
            run_word  = 1'b1;
          end
        end
      end
      MODE_LINE: begin
        if (text_byte == 8'd0) begin
          mode_next = MODE_IDLE;
          res[cnt[1:0]] = mk(KIND_EOT, 8'd0, 1'b0, 10'd0);
          cnt = cnt + 3'd1;
        end else if (text_byte == CH_NEWLINE) begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_BLOCK, MODE_BLOCK_STAR: begin
        if (text_byte == 8'd0) begin
          mode_next = MODE_IDLE;
          res[cnt[1:0]] = mk(KIND_EOT, 8'd0, 1'b0, 10'd0);
          cnt = cnt + 3'd1;
        end else if (text_byte == CH_STAR) begin
          mode_next = MODE_BLOCK_STAR;
        end else if ((text_byte == CH_SLASH) && (mode == MODE_BLOCK_STAR)) begin
          mode_next = MODE_IDLE;
        end else begin
          mode_next = MODE_BLOCK;
        end
      end
      MODE_WORD: begin
        run_word = 1'b1;
      end
      MODE_QUOTE: begin
        if ((text_byte == CH_DQUOTE) || (text_byte == 8'd0)) begin
          res[cnt[1:0]] = mk(KIND_END, 8'd0, 1'b1, chars_next);
          cnt = cnt + 3'd1;
          chars_next = 10'd0;
          mode_next  = MODE_IDLE;
          if (text_byte == 8'd0) begin
            res[cnt[1:0]] = mk(KIND_EOT, 8'd0, 1'b0, 10'd0);
            cnt = cnt + 3'd1;
          end
        end else begin
          res[cnt[1:0]] = mk(KIND_CHAR, cf, 1'b1, 10'd0);
          cnt = cnt + 3'd1;
          chars_next = chars_next + 10'd1;
          if (chars_next >= cap) begin
            res[cnt[1:0]] = mk(KIND_END, 8'd0, 1'b1, chars_next);
            cnt = cnt + 3'd1;
            chars_next = 10'd0;
            mode_next  = MODE_IDLE;
          end
        end
      end
      default: begin
        mode_next = MODE_IDLE;
        run_idle  = 1'b1;
      end
    endcase

    if (run_word) begin
      if ((text_byte == 8'd0) || is_brk || is_sp) begin
        res[cnt[1:0]] = mk(KIND_END, 8'd0, 1'b0, chars_next);
        cnt = cnt + 3'd1;
        chars_next = 10'd0;
        mode_next  = MODE_IDLE;
        if ((text_byte == 8'd0) || is_brk) run_idle = 1'b1;
      end else begin
        res[cnt[1:0]] = mk(KIND_CHAR, cf, 1'b0, 10'd0);
        cnt = cnt + 3'd1;
        chars_next = chars_next + 10'd1;
        if (chars_next >= cap) begin
          res[cnt[1:0]] = mk(KIND_END, 8'd0, 1'b0, chars_next);
          cnt = cnt + 3'd1;
          chars_next = 10'd0;
          mode_next  = MODE_IDLE;
        end
      end
    end

    if (run_idle) begin
      if (text_byte == 8'd0) begin
        res[cnt[1:0]] = mk(KIND_EOT, 8'd0, 1'b0, 10'd0);
        cnt = cnt + 3'd1;
      end else if (is_sp) begin
        mode_next = MODE_IDLE;
      end else if (text_byte == CH_SLASH) begin
        mode_next = MODE_SLASH;
      end else if (text_byte == CH_DQUOTE) begin
        mode_next  = MODE_QUOTE;
        chars_next = 10'd0;
      end else if (is_brk) begin
        res[cnt[1:0]] = mk(KIND_CHAR, cf, 1'b0, 10'd0);
        cnt = cnt + 3'd1;
        res[cnt[1:0]] = mk(KIND_END, 8'd0, 1'b0, 10'd1);
        cnt = cnt + 3'd1;
      end else begin
        mode_next = MODE_WORD;
        res[cnt[1:0]] = mk(KIND_CHAR, cf, 1'b0, 10'd0);
        cnt = cnt + 3'd1;
        chars_next = 10'd1;
        if (chars_next >= cap) begin
          res[cnt[1:0]] = mk(KIND_END, 8'd0, 1'b0, chars_next);
          cnt = cnt + 3'd1;
          chars_next = 10'd0;
          mode_next  = MODE_IDLE;
        end
      end
    end
  end

  assign bundle.res   = res;
  assign bundle.count = cnt;
  assign push = step && (cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      chars <= 10'd0;
    end else if (step) begin
      mode  <= mode_next;
      chars <= chars_next;
    end
  end

endmodule

// File: src/ctt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_queue: short bundle queue between scanner and emitter
// A two-entry first-in first-out store of result bundles.
// ----------------------------------------------------------------------------
module ctt_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ctt_pkg::bundle_t       din,
  input  logic                   pop,
  output ctt_pkg::bundle_t       dout,
  output ctt_pkg::queue_status_t status
);
  import ctt_pkg::*;

  bundle_t                mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  function automatic logic [QUEUE_PTR_W-1:0] bump(logic [QUEUE_PTR_W-1:0] p);
    if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) return '0;
    return p + QUEUE_PTR_W'(1);
  endfunction

  assign status.full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign dout = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      count <= count + QUEUE_CNT_W'(1);
      else if (pop && !push) count <= count - QUEUE_CNT_W'(1);
    end
  end

endmodule

// File: src/ctt_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_emitter: back end of the tokenizer
// Holds one bundle and hands its results out one word per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module ctt_emitter (
  input  logic              clk,
  input  logic              rst,
  input  ctt_pkg::bundle_t  head,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output ctt_pkg::result_t  cur
);
  import ctt_pkg::*;

  bundle_t    bund;
  logic [1:0] pos;
  logic       busy;
  logic       fire;
  logic       last;

  assign fire = busy && out_ready;
  assign last = ({1'b0, pos} == (bund.count - 3'd1));
  assign pop  = head_valid && (!busy || (fire && last));
  assign out_valid = busy;
  assign cur = bund.res[pos];

  always_ff @(posedge clk) begin
    if (pop) bund <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= 2'd0;
    end else if (pop) begin
      busy <= 1'b1;
      pos  <= 2'd0;
    end else if (fire && last) begin
      busy <= 1'b0;
    end else if (fire) begin
      pos <= pos + 2'd1;
    end
  end

endmodule

// File: src/comment_aware_text_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comment_aware_text_tokenizer: byte-stream tokenizer that skips comments
// Splits text into tokens, skipping whitespace and line and block comments.
// ----------------------------------------------------------------------------
// Usage:
// Text bytes enter on the in_valid/in_ready channel, one word per byte; a zero
// byte ends the text. Results leave on the out_valid/out_ready channel, one
// word per result: a token character, an end of token with its length, or an
// end of text. The cfg channel writes token_limit, colon_is_break and
// fold_case by index; it is always ready and should be used only while no
// results are outstanding.
// A byte is classified in the cycle it is accepted and its results (up to
// four), if any, are queued as one bundle; the first result is offered once
// the bundle has passed the queue and been loaded into the emitter.
// Throughput is one byte per cycle while each byte causes at most one
// result and out_ready stays high; a byte with several results holds the
// output until all are taken, which sets the sustained rate. A two-entry
// bundle queue between scanner and emitter keeps input flowing while the
// receiver stalls until the queue fills; then in_ready drops and nothing is lost.
// Reset clears the scan mode, the token count and the queue, and returns the
// registers to token_limit 1024, colon_is_break 1 and fold_case 1.
// ----------------------------------------------------------------------------
module comment_aware_text_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [7:0]  token_char,
  output logic        was_quoted,
  output logic [9:0]  token_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import ctt_pkg::*;

  cfg_t          cfg;
  logic          step;
  logic          push;
  logic          pop;
  bundle_t       push_bundle;
  bundle_t       head;
  queue_status_t qstat;
  result_t       cur;

  // Configuration registers. Writes are always taken; an unused index is
  // simply ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.token_limit    <= TOKEN_LIMIT_RESET;
      cfg.colon_is_break <= 1'b1;
      cfg.fold_case      <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TOKEN_LIMIT:    cfg.token_limit    <= cfg_data;
        CFG_COLON_IS_BREAK: cfg.colon_is_break <= cfg_data[0];
        CFG_FOLD_CASE:      cfg.fold_case      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The scanner may take a byte whenever the queue has a free entry, since
  // one byte never needs more than one bundle.
  assign in_ready = !qstat.full;
  assign step     = in_valid && in_ready;

  ctt_scanner u_scanner (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .text_byte (text_byte),
    .push      (push),
    .bundle    (push_bundle)
  );

  ctt_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (push_bundle),
    .pop    (pop),
    .dout   (head),
    .status (qstat)
  );

  ctt_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!qstat.empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cur        (cur)
  );

  assign result_kind  = cur.kind;
  assign token_char   = cur.ch;
  assign was_quoted   = cur.quoted;
  assign token_length = cur.len;

  // A bundle is only queued when it holds results and there is room.
  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_bundle.count != 3'd0))
    else $error("empty bundle pushed");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("bundle pushed into a full queue");

  // End of text carries no character, length or quote mark.
  a_eot_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_kind == KIND_EOT)) |->
      ((token_char == 8'd0) && (token_length == 10'd0) && !was_quoted))
    else $error("end of text with payload");

  // Only a quoted token can be empty.
  a_word_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_kind == KIND_END) && !was_quoted) |->
      (token_length != 10'd0))
    else $error("unquoted token of length zero");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for comment_aware_text_tokenizer
// Streams directed and random text into the tokenizer. A byte-level
// predictor of the scanner builds the expected result words, and a monitor
// compares every result word that the block hands out against them.
// ----------------------------------------------------------------------------
module testbench;
  import ctt_pkg::*;

  // Run control. The cycle limit is far above the slowest legal run: a few
  // thousand text bytes, up to four result words each, and a receiver that
  // can sit at one ready in eight for long stretches.
  localparam int unsigned CYCLE_LIMIT      = 1000000;
  localparam int          SETTLE_CYCLES    = 4;
  localparam int          LONG_HOLD_CYCLES = 300;

  // Characters the bench needs beyond those of the package.
  localparam logic [7:0] CH_NUL = 8'h00;

  // The register index space has one slot with no register behind it.
  localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

  // How the receiver treats out_ready during one stretch of cycles.
  typedef enum {RX_STEADY, RX_PATTERN, RX_SPARSE} rx_style_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  text_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  result_kind;
  logic [7:0]  token_char;
  logic        was_quoted;
  logic [9:0]  token_length;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;

  // Predictor copy of the scanner state and of the registers.
  mode_t       scan_state;
  int          token_fill;
  logic [10:0] limit_reg;
  logic        colon_reg;
  logic        fold_reg;

  // Result words the block still owes, oldest first.
  result_t     predicted_results[$];
  result_t     next_expected;
  int unsigned predicted_total;

  // Bytes that produced a result or moved the scanner; ignored bytes do not
  // count toward the length of a random phase.
  int unsigned live_items;
  int unsigned fail_count;
  int unsigned cycle_count;

  // Sender and receiver pacing.
  int          burst_left;
  bit          steady_sender;
  bit          hold_request;
  rx_style_t   rx_style;
  int          style_left;
  int          rx_pick;
  logic [31:0] stall_pattern;

  comment_aware_text_tokenizer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .text_byte    (text_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .token_char   (token_char),
    .was_quoted   (was_quoted),
    .token_length (token_length),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // A token holds at most limit-1 characters; the limit is clamped to the
  // legal range before use, so 0 and 1 act as 2 and anything above the
  // maximum acts as the maximum.
  function automatic int char_cap();
    int lim;
    lim = limit_reg;
    if (lim < TOKEN_LIMIT_MIN) lim = TOKEN_LIMIT_MIN;
    if (lim > TOKEN_LIMIT_MAX) lim = TOKEN_LIMIT_MAX;
    return lim - 1;
  endfunction

  function automatic bit is_break_char(logic [7:0] c);
    return c == CH_LBRACE || c == CH_RBRACE || c == CH_LPAREN || c == CH_RPAREN ||
           c == CH_SQUOTE || (colon_reg && c == CH_COLON);
  endfunction

  // Control bytes, space and everything with the top bit set separate tokens.
  function automatic bit is_blank(logic [7:0] c);
    return c <= CH_SPACE || c[7];
  endfunction

  function automatic logic [7:0] fold_char(logic [7:0] c);
    if (fold_reg && c >= CH_UPPER_A && c <= CH_UPPER_Z) return c + CASE_OFFSET;
    return c;
  endfunction

  function automatic void push_result(kind_t k, logic [7:0] ch, logic q, int len);
    result_t r;
    r.kind   = k;
    r.ch     = ch;
    r.quoted = q;
    r.len    = len[9:0];
    predicted_results.push_back(r);
    predicted_total++;
  endfunction

  // Adds one character to the open token and cuts the token once it is full.
  // After a cut the scanner is back between tokens, even inside a string.
  function automatic void append_char(logic [7:0] c, logic q);
    push_result(KIND_CHAR, fold_char(c), q, 0);
    token_fill++;
    if (token_fill >= char_cap()) begin
      push_result(KIND_END, CH_NUL, q, token_fill);
      token_fill = 0;
      scan_state = MODE_IDLE;
    end
  endfunction

  function automatic void scan_between(logic [7:0] c);
    if (c == CH_NUL) begin
      push_result(KIND_EOT, CH_NUL, 1'b0, 0);
      return;
    end
    if (is_blank(c)) return;
    if (c == CH_SLASH) begin
      scan_state = MODE_SLASH;
      return;
    end
    if (c == CH_DQUOTE) begin
      scan_state = MODE_QUOTE;
      token_fill = 0;
      return;
    end
    if (is_break_char(c)) begin
      push_result(KIND_CHAR, fold_char(c), 1'b0, 0);
      push_result(KIND_END, CH_NUL, 1'b0, 1);
      return;
    end
    token_fill = 0;
    scan_state = MODE_WORD;
    append_char(c, 1'b0);
  endfunction

  // Inside a word token, blanks, breaks and the zero byte close it; a break
  // or a zero byte is then handled again as if between tokens.
  function automatic void scan_in_word(logic [7:0] c);
    if (is_blank(c) || is_break_char(c)) begin
      push_result(KIND_END, CH_NUL, 1'b0, token_fill);
      token_fill = 0;
      scan_state = MODE_IDLE;
      if (c == CH_NUL || is_break_char(c)) scan_between(c);
      return;
    end
    append_char(c, 1'b0);
  endfunction

  function automatic void tokenize_byte(logic [7:0] c);
    case (scan_state)
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          scan_state = MODE_LINE;
        end else if (c == CH_STAR) begin
          scan_state = MODE_BLOCK;
        end else begin
          // A lone slash opens a word token; the pending byte follows it.
          token_fill = 0;
          scan_state = MODE_WORD;
          append_char(CH_SLASH, 1'b0);
          if (scan_state == MODE_WORD) scan_in_word(c);
          else scan_between(c);
        end
      end
      MODE_LINE: begin
        if (c == CH_NUL) begin
          scan_state = MODE_IDLE;
          push_result(KIND_EOT, CH_NUL, 1'b0, 0);
        end else if (c == CH_NEWLINE) begin
          scan_state = MODE_IDLE;
        end
      end
      MODE_BLOCK, MODE_BLOCK_STAR: begin
        if (c == CH_NUL) begin
          scan_state = MODE_IDLE;
          push_result(KIND_EOT, CH_NUL, 1'b0, 0);
        end else if (c == CH_STAR) begin
          scan_state = MODE_BLOCK_STAR;
        end else if (c == CH_SLASH && scan_state == MODE_BLOCK_STAR) begin
          scan_state = MODE_IDLE;
        end else begin
          scan_state = MODE_BLOCK;
        end
      end
      MODE_WORD: scan_in_word(c);
      MODE_QUOTE: begin
        if (c == CH_DQUOTE || c == CH_NUL) begin
          push_result(KIND_END, CH_NUL, 1'b1, token_fill);
          token_fill = 0;
          scan_state = MODE_IDLE;
          if (c == CH_NUL) push_result(KIND_EOT, CH_NUL, 1'b0, 0);
        end else begin
          append_char(c, 1'b1);
        end
      end
      default: begin
        scan_state = MODE_IDLE;
        scan_between(c);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offers one text byte and holds it until the block takes it. The task is
  // entered and left at a falling edge. It never lowers in_valid itself
  // except for a gap between bursts, so a following call can keep valid high
  // without a second assignment in the same step.
  task automatic send_byte(input logic [7:0] c);
    int unsigned total_before;
    mode_t       state_before;
    int          gap;
    text_byte <= c;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!in_ready);
    total_before = predicted_total;
    state_before = scan_state;
    tokenize_byte(c);
    if (predicted_total != total_before || scan_state != state_before) live_items++;
    @(negedge clk);
    if (!steady_sender) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Leaves cfg_valid high so that back-to-back writes need no toggle; the
  // caller lowers it after the last write.
  task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TOKEN_LIMIT) limit_reg = data;
    else if (idx == CFG_COLON_IS_BREAK) colon_reg = data[0];
    else if (idx == CFG_FOLD_CASE) fold_reg = data[0];
    @(negedge clk);
  endtask

  task automatic configure(input logic [10:0] limit, input logic colon, input logic fold);
    write_reg(CFG_TOKEN_LIMIT, limit);
    write_reg(CFG_COLON_IS_BREAK, {10'd0, colon});
    write_reg(CFG_FOLD_CASE, {10'd0, fold});
    cfg_valid <= 1'b0;
  endtask

  // The sender stops until every predicted word has come back. A byte that
  // causes no result may still be in flight, so a settle wait follows.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (predicted_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Random text
  // --------------------------------------------------------------------------

  // Bytes from 33 to 127 that continue a word token. A leading byte must not open
  // a comment or a string, so slash and double quote are kept out of it.
  function automatic logic [7:0] pick_word_char(bit lead);
    logic [7:0] c;
    do c = 8'($urandom_range(33, 127));
    while (is_break_char(c) || (lead && (c == CH_SLASH || c == CH_DQUOTE)));
    return c;
  endfunction

  function automatic logic [7:0] pick_break_char();
    case ($urandom_range(0, 5))
      0:       return CH_LBRACE;
      1:       return CH_RBRACE;
      2:       return CH_LPAREN;
      3:       return CH_RPAREN;
      4:       return CH_SQUOTE;
      default: return CH_COLON;
    endcase
  endfunction

  // Mostly well-formed pieces of text with random content, plus some broken
  // pieces (unclosed strings and comments) and raw noise bytes.
  task automatic send_fragment();
    int         n;
    logic [7:0] c;
    case ($urandom_range(0, 11))
      0, 1, 2, 3: begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        send_byte(pick_word_char(1'b1));
        repeat (n - 1) send_byte(pick_word_char(1'b0));
      end
      4: begin
        send_byte(CH_DQUOTE);
        n = $urandom_range(0, 6);
        repeat (n) begin
          do c = 8'($urandom_range(1, 255)); while (c == CH_DQUOTE);
          send_byte(c);
        end
        if ($urandom_range(0, 5) != 0) send_byte(CH_DQUOTE);
      end
      5: send_byte(pick_break_char());
      6: send_byte(($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 32))
                                              : 8'($urandom_range(128, 255)));
      7: begin
        send_byte(CH_SLASH);
        send_byte(CH_SLASH);
        n = $urandom_range(0, 5);
        repeat (n) begin
          do c = 8'($urandom_range(1, 255)); while (c == CH_NEWLINE);
          send_byte(c);
        end
        send_byte(($urandom_range(0, 7) == 0) ? CH_NUL : CH_NEWLINE);
      end
      8: begin
        send_byte(CH_SLASH);
        send_byte(CH_STAR);
        n = $urandom_range(0, 6);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0:       send_byte(CH_STAR);
            1:       send_byte(CH_SLASH);
            default: send_byte(8'($urandom_range(1, 255)));
          endcase
        end
        if ($urandom_range(0, 5) != 0) begin
          send_byte(CH_STAR);
          send_byte(CH_SLASH);
        end
      end
      9: begin
        // A slash that opens neither kind of comment.
        send_byte(CH_SLASH);
        do c = 8'($urandom_range(1, 255)); while (c == CH_SLASH || c == CH_STAR);
        send_byte(c);
      end
      10: send_byte(CH_NUL);
      default: begin
        n = $urandom_range(1, 3);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // Every phase ends with a zero byte so the next one starts between tokens.
  task automatic run_random_text(input int count);
    int unsigned start;
    start = live_items;
    while (live_items - start < count) send_fragment();
    send_byte(CH_NUL);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corner cases under the reset settings: folded capitals, breaks and the
  // colon, an empty string, a block comment with slash-star-slash and a
  // double star before its close, a line comment, a lone slash starting a
  // word token, a high byte as blank, a high byte inside quotes, a zero byte
  // closing a string, a zero byte inside a comment, a quote ending a word
  // token, and a slash right before the zero byte.
  task automatic test_directed();
    send_text("AZ{:\"\"/*/**///\n/q\377\"\200");
    send_byte(CH_NUL);
    send_text("/*");
    send_byte(CH_NUL);
    send_text("w'/");
    send_byte(CH_NUL);
  endtask

  // Length cuts: one token at the largest length with an out-of-range limit,
  // then the clamped low limits, the unused register slot and a string that
  // is cut and continues as unquoted text.
  task automatic test_length_cut();
    wait_for_results();
    configure(11'h7ff, 1'b1, 1'b1);
    send_byte(pick_word_char(1'b1));
    repeat (1029) send_byte(pick_word_char(1'b0));
    send_byte(CH_SPACE);
    wait_for_results();
    configure(11'd0, 1'b0, 1'b0);
    send_text("Ab:\"Cd\"");
    run_random_text(30);
    wait_for_results();
    write_reg(CFG_UNUSED_INDEX, 11'h7ff);
    configure(11'd1, 1'b1, 1'b0);
    run_random_text(20);
    wait_for_results();
    configure(11'd3, 1'b1, 1'b1);
    send_text("\"abcde\" \"XY\"");
    run_random_text(20);
  endtask

  // The receiver holds off for a long stretch while the sender keeps going,
  // so the bundle queue fills and in_ready drops.
  task automatic test_backpressure();
    wait_for_results();
    configure(11'd64, 1'b1, 1'b1);
    steady_sender = 1'b1;
    hold_request  = 1'b1;
    repeat (80) send_byte(($urandom_range(0, 4) == 0) ? CH_LPAREN : pick_word_char(1'b1));
    send_byte(CH_NUL);
    steady_sender = 1'b0;
  endtask

  task automatic test_random_text(input int phases, input int per_phase);
    logic [10:0] limit;
    for (int p = 0; p < phases; p++) begin
      wait_for_results();
      case ($urandom_range(0, 4))
        0:       limit = TOKEN_LIMIT_MIN;
        1:       limit = 11'($urandom_range(3, 12));
        2:       limit = 11'($urandom_range(13, 200));
        3:       limit = TOKEN_LIMIT_MAX;
        default: limit = 11'($urandom_range(1025, 2047));
      endcase
      configure(limit, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      run_random_text(per_phase);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver and monitor
  // --------------------------------------------------------------------------

  // out_ready follows a style that is drawn anew whenever the current one runs
  // out: always ready, a random bit pattern, or ready only now and then. A hold
  // request from a test first holds out_ready low for a long stretch.
  always begin
    @(negedge clk);
    if (hold_request) begin
      hold_request = 1'b0;
      out_ready <= 1'b0;
      repeat (LONG_HOLD_CYCLES) @(negedge clk);
    end
    if (style_left <= 0) begin
      style_left    = 64;
      stall_pattern = $urandom;
      rx_pick       = $urandom_range(0, 3);
      if (rx_pick < 2) rx_style = RX_STEADY;
      else if (rx_pick == 2) rx_style = RX_PATTERN;
      else rx_style = RX_SPARSE;
    end
    style_left--;
    case (rx_style)
      RX_STEADY:  out_ready <= 1'b1;
      RX_PATTERN: out_ready <= stall_pattern[style_left % 32];
      default:    out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic void compare_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %h, got %h", $time, field, want, got);
    end
  endfunction

  // Each result word taken at a rising edge is checked against the oldest
  // prediction. Results are offered no earlier than the cycle after their
  // byte, so a push and a pop in the same step never concern the same word.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (predicted_results.size() == 0) begin
        fail_count++;
        $display("%0t: result kind %h char %h with none expected", $time, result_kind,
                 token_char);
      end else begin
        next_expected = predicted_results.pop_front();
        compare_field("result_kind", next_expected.kind, result_kind);
        compare_field("token_char", next_expected.ch, token_char);
        compare_field("was_quoted", next_expected.quoted, was_quoted);
        compare_field("token_length", next_expected.len, token_length);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("comment_aware_text_tokenizer: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    text_byte     = CH_NUL;
    out_ready     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_TOKEN_LIMIT;
    cfg_data      = '0;
    steady_sender = 1'b0;
    hold_request  = 1'b0;
    burst_left    = 0;
    style_left    = 0;
    rx_style      = RX_STEADY;
    fail_count    = 0;
    cycle_count   = 0;
    live_items    = 0;
    predicted_total = 0;

    // Predictor state right after reset.
    scan_state = MODE_IDLE;
    token_fill = 0;
    limit_reg  = TOKEN_LIMIT_RESET;
    colon_reg  = 1'b1;
    fold_reg   = 1'b1;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_length_cut();
    test_backpressure();
    test_random_text(4, 100);

    wait_for_results();
    if (fail_count == 0) begin
      $display("comment_aware_text_tokenizer: match");
    end else begin
      $display("comment_aware_text_tokenizer: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
src/ctt_pkg.sv
src/ctt_scanner.sv
src/ctt_queue.sv
src/ctt_emitter.sv
src/comment_aware_text_tokenizer.sv
tb/sv/testbench.sv
